@@ hw/rtl/gncl_pkg.sv @@
// Shared types, constants and helpers of the grid neighbour cell lister.
package gncl_pkg;

   localparam int SIDE_W     = 9;
   localparam int MAX_SIDE   = 256;
   localparam int CELL_W     = 16;
   localparam int COUNT_W    = 17;
   localparam int COL_W      = 8;
   localparam int OP_W       = 2;
   localparam int DIR_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int SLOT_COUNT = 9;
   localparam int SLOT_W     = 4;
   localparam int POS_W      = 4;
   localparam int STEP_W     = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [OP_W-1:0] OP_BLOCK = 2'd0;
   localparam logic [OP_W-1:0] OP_ENTER = 2'd1;
   localparam logic [OP_W-1:0] OP_LEAVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_LISTED       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_CELL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_COUNT  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [CELL_W-1:0] cell_index;
      logic [DIR_W-1:0]  direction;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0]   neighbour_index;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  width;
      logic [SIDE_W-1:0]  height;
      logic [COUNT_W-1:0] count;
   } grid_type;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [CELL_W-1:0]   cell_index;
      logic [DIR_W-1:0]    direction;
      logic [COL_W-1:0]    col;
      logic [CELL_W-1:0]   row;
      logic [STATUS_W-1:0] status;
   } entry_type;

   typedef struct packed {
      logic x_neg;
      logic x_pos;
      logic y_neg;
      logic y_pos;
   } offset_type;

   function automatic offset_type ring_offset(input logic [POS_W-1:0] pos);
      offset_type off;
      off = '0;
      case (pos)
         4'd0: off.y_neg = 1'b1;
         4'd1: begin off.y_neg = 1'b1; off.x_pos = 1'b1; end
         4'd2: off.x_pos = 1'b1;
         4'd3: begin off.y_pos = 1'b1; off.x_pos = 1'b1; end
         4'd4: off.y_pos = 1'b1;
         4'd5: begin off.y_pos = 1'b1; off.x_neg = 1'b1; end
         4'd6: off.x_neg = 1'b1;
         4'd7: begin off.y_neg = 1'b1; off.x_neg = 1'b1; end
         default: off = '0;
      endcase
      return off;
   endfunction

endpackage

@@ hw/rtl/grid_neighbour_cell_lister.sv @@
// Top level of the grid neighbour cell lister.
//
// A request (operation, centre cell index, move direction) is taken at a
// rising clock edge where start is high and busy is low. The block answers
// with one to nine results, each shown on rsp_payload for a single cycle
// while rsp_valid is high; the final result of a request carries last.
// The results of a request come on consecutive cycles and cannot be held off by the receiver.
// The grid shape is set through the csr_ write port: index 0 width, index 1
// height, index 2 cell count. Write it only while no request is in flight.
// A centre index that is checked and split into column and row is taken
// into the front end, then passes through a divider that resolves two
// quotient bits per cycle, and is then handed on to the queue. A request
// rejected up front needs no division and goes straight to being handed on.
// The front end takes no new request while the divider works; it takes one
// again as it hands on the last, while the back end still sends the results
// of earlier ones, so the divider sets the rate unless the queue is full.
// Reset empties the queue, drops pending results and sets all three
// registers to one.
module grid_neighbour_cell_lister (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  gncl_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   output gncl_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_write,
   input  logic [gncl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gncl_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [gncl_pkg::SIDE_W-1:0]  width_ff, width_in;
   logic [gncl_pkg::SIDE_W-1:0]  height_ff, height_in;
   logic [gncl_pkg::COUNT_W-1:0] count_ff, count_in;

   gncl_pkg::grid_type           grid;
   logic                         queue_full;
   logic                         push_valid;
   gncl_pkg::entry_type          push_entry;
   logic                         pop;
   logic                         head_valid;
   gncl_pkg::entry_type          head_entry;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      count_in  = count_ff;
      if (csr_write) begin
         unique case (csr_index)
            gncl_pkg::CSR_GRID_WIDTH:  width_in  = csr_wdata[gncl_pkg::SIDE_W-1:0];
            gncl_pkg::CSR_GRID_HEIGHT: height_in = csr_wdata[gncl_pkg::SIDE_W-1:0];
            gncl_pkg::CSR_CELL_COUNT:  count_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gncl_pkg::SIDE_W'(1);
         height_ff <= gncl_pkg::SIDE_W'(1);
         count_ff  <= gncl_pkg::COUNT_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         count_ff  <= count_in;
      end
   end

   assign grid.width  = (width_ff > gncl_pkg::SIDE_W'(gncl_pkg::MAX_SIDE)) ?
                        gncl_pkg::SIDE_W'(gncl_pkg::MAX_SIDE) : width_ff;
   assign grid.height = (height_ff > gncl_pkg::SIDE_W'(gncl_pkg::MAX_SIDE)) ?
                        gncl_pkg::SIDE_W'(gncl_pkg::MAX_SIDE) : height_ff;
   assign grid.count  = count_ff;

   gncl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .grid        (grid),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   gncl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   gncl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .grid        (grid),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   a_error_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != gncl_pkg::ST_LISTED) |->
         rsp_payload.last && (rsp_payload.neighbour_index == '0))
      else $error("error result is not a single zero result");

   a_run_unbroken : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |=> rsp_valid)
      else $error("result run broken before last");

   a_pop_has_data : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule

@@ hw/rtl/gncl_front.sv @@
// Front end: accepts requests, screens them and splits the centre index into column and row.
module gncl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  gncl_pkg::req_type   req_payload,
   input  gncl_pkg::grid_type  grid,
   input  logic                queue_full,
   output logic                push_valid,
   output gncl_pkg::entry_type push_entry
);

   typedef enum logic [1:0] {S_IDLE, S_DIVIDE, S_PUSH} state_type;

   state_type                       state_ff, state_in;
   gncl_pkg::entry_type             entry_ff, entry_in;
   logic [gncl_pkg::CELL_W-1:0]     quo_ff, quo_in;
   logic [gncl_pkg::COL_W-1:0]      rem_ff, rem_in;
   logic [gncl_pkg::STEP_W-1:0]     step_ff, step_in;

   logic                            accept;
   logic                            push;
   logic [gncl_pkg::CELL_W-1:0]     quo_a, quo_b;
   logic [gncl_pkg::COL_W-1:0]      rem_a, rem_b;
   logic [gncl_pkg::SIDE_W-1:0]     trial_a, trial_b;
   logic                            ge_a, ge_b;
   logic [gncl_pkg::STATUS_W-1:0]   screen;

   assign push       = (state_ff == S_PUSH) && !queue_full;
   assign busy       = (state_ff == S_DIVIDE) || ((state_ff == S_PUSH) && queue_full);
   assign accept     = start && !busy;
   assign push_valid = push;
   assign push_entry = entry_ff;

   // Two restoring division steps per cycle.
   always_comb begin
      trial_a = {rem_ff, quo_ff[gncl_pkg::CELL_W-1]};
      ge_a    = trial_a >= grid.width;
      rem_a   = ge_a ? gncl_pkg::COL_W'(trial_a - grid.width) : trial_a[gncl_pkg::COL_W-1:0];
      quo_a   = {quo_ff[gncl_pkg::CELL_W-2:0], ge_a};
      trial_b = {rem_a, quo_a[gncl_pkg::CELL_W-1]};
      ge_b    = trial_b >= grid.width;
      rem_b   = ge_b ? gncl_pkg::COL_W'(trial_b - grid.width) : trial_b[gncl_pkg::COL_W-1:0];
      quo_b   = {quo_a[gncl_pkg::CELL_W-2:0], ge_b};
   end

   always_comb begin
      if ({1'b0, req_payload.cell_index} >= grid.count) begin
         screen = gncl_pkg::ST_OUT_OF_RANGE;
      end else if ((grid.width == '0) || (grid.height == '0) ||
                   ((req_payload.operation != gncl_pkg::OP_BLOCK) &&
                    (req_payload.operation != gncl_pkg::OP_ENTER) &&
                    (req_payload.operation != gncl_pkg::OP_LEAVE))) begin
         screen = gncl_pkg::ST_NO_CELL;
      end else begin
         screen = gncl_pkg::ST_LISTED;
      end
   end

   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE, S_PUSH: begin
            if (push) begin
               state_in = S_IDLE;
            end
            if (accept) begin
               entry_in.operation  = req_payload.operation;
               entry_in.cell_index = req_payload.cell_index;
               entry_in.direction  = req_payload.direction;
               entry_in.col        = '0;
               entry_in.row        = '0;
               entry_in.status     = screen;
               quo_in              = req_payload.cell_index;
               rem_in              = '0;
               step_in             = '0;
               state_in            = (screen == gncl_pkg::ST_LISTED) ? S_DIVIDE : S_PUSH;
            end
         end
         S_DIVIDE: begin
            quo_in  = quo_b;
            rem_in  = rem_b;
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               entry_in.col = rem_b;
               entry_in.row = quo_b;
               state_in     = S_PUSH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      entry_ff <= entry_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
   end

endmodule

@@ hw/rtl/gncl_queue.sv @@
// Two-entry queue between the front end and the back end.
module gncl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  gncl_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output gncl_pkg::entry_type head_entry
);

   gncl_pkg::entry_type entries_ff [2];
   logic                head_ff, head_in;
   logic [1:0]          count_ff, count_in;
   logic                tail;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_entry = entries_ff[head_ff];
   assign tail       = head_ff ^ count_ff[0];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop) begin
         head_in  = !head_ff;
         count_in = count_in - 1'b1;
      end
      if (push_valid) begin
         count_in = count_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      if (push_valid) begin
         entries_ff[tail] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/gncl_back.sv @@
// Back end: works out which listed cells are in bounds and sends one result per cycle.
module gncl_back (
   input  logic                clock,
   input  logic                reset,
   input  gncl_pkg::grid_type  grid,
   input  logic                head_valid,
   input  gncl_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   output gncl_pkg::rsp_type   rsp_payload
);

   function automatic logic slot_used(input logic [gncl_pkg::OP_W-1:0] op,
                                      input logic [gncl_pkg::DIR_W-1:0] dir,
                                      input logic [gncl_pkg::SLOT_W-1:0] k);
      logic used;
      case (op)
         gncl_pkg::OP_BLOCK: used = 1'b1;
         gncl_pkg::OP_ENTER, gncl_pkg::OP_LEAVE: used = k < (dir[0] ? 4'd5 : 4'd3);
         default: used = 1'b0;
      endcase
      return used;
   endfunction

   function automatic logic [gncl_pkg::POS_W-1:0] slot_pos(
         input logic [gncl_pkg::OP_W-1:0]   op,
         input logic [gncl_pkg::DIR_W-1:0]  dir,
         input logic [gncl_pkg::SLOT_W-1:0] k);
      logic [gncl_pkg::POS_W-1:0] pos;
      case (op)
         gncl_pkg::OP_BLOCK: pos = k;
         gncl_pkg::OP_ENTER: pos = {1'b0, 3'((dir[0] ? 3'd6 : 3'd7) + k[2:0] + dir)};
         gncl_pkg::OP_LEAVE: pos = {1'b0, 3'((dir[0] ? 3'd2 : 3'd3) + k[2:0] + dir)};
         default: pos = '0;
      endcase
      return pos;
   endfunction

   function automatic logic in_bounds(input gncl_pkg::offset_type off,
                                      input logic [gncl_pkg::COL_W-1:0]  col,
                                      input logic [gncl_pkg::CELL_W-1:0] row,
                                      input gncl_pkg::grid_type g);
      logic x_ok;
      logic y_ok;
      if (off.x_neg) begin
         x_ok = col != '0;
      end else if (off.x_pos) begin
         x_ok = ({1'b0, col} + 1'b1) < g.width;
      end else begin
         x_ok = {1'b0, col} < g.width;
      end
      if (off.y_neg) begin
         y_ok = (row != '0) && (row <= gncl_pkg::CELL_W'(g.height));
      end else if (off.y_pos) begin
         y_ok = ({1'b0, row} + 1'b1) < gncl_pkg::COUNT_W'(g.height);
      end else begin
         y_ok = row < gncl_pkg::CELL_W'(g.height);
      end
      return x_ok && y_ok;
   endfunction

   logic                                active_ff, active_in;
   logic [gncl_pkg::SLOT_COUNT-1:0]     mask_ff, mask_in;
   logic [gncl_pkg::STATUS_W-1:0]       err_ff, err_in;
   gncl_pkg::entry_type                 item_ff, item_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   gncl_pkg::rsp_type                   rsp_ff, rsp_in;

   logic [gncl_pkg::SLOT_COUNT-1:0]     head_mask;
   logic [gncl_pkg::SLOT_COUNT-1:0]     sel_onehot;
   logic [gncl_pkg::SLOT_COUNT-1:0]     rest;
   logic [gncl_pkg::SLOT_W-1:0]         sel;
   gncl_pkg::offset_type                off;
   logic [gncl_pkg::CELL_W-1:0]         x_step, y_step;
   logic                                done;
   logic                                load;

   always_comb begin
      for (int k = 0; k < gncl_pkg::SLOT_COUNT; k++) begin
         head_mask[k] =
            slot_used(head_entry.operation, head_entry.direction, gncl_pkg::SLOT_W'(k)) &&
            in_bounds(gncl_pkg::ring_offset(slot_pos(head_entry.operation,
                         head_entry.direction, gncl_pkg::SLOT_W'(k))),
                      head_entry.col, head_entry.row, grid);
      end
   end

   always_comb begin
      sel = '0;
      for (int k = gncl_pkg::SLOT_COUNT - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            sel = gncl_pkg::SLOT_W'(k);
         end
      end
      sel_onehot = gncl_pkg::SLOT_COUNT'(1) << sel;
      rest       = mask_ff & ~sel_onehot;
      off        = gncl_pkg::ring_offset(slot_pos(item_ff.operation, item_ff.direction, sel));
      x_step     = off.x_pos ? gncl_pkg::CELL_W'(1) : (off.x_neg ? '1 : '0);
      if (off.y_pos) begin
         y_step = gncl_pkg::CELL_W'(grid.width);
      end else if (off.y_neg) begin
         y_step = gncl_pkg::CELL_W'(-gncl_pkg::CELL_W'(grid.width));
      end else begin
         y_step = '0;
      end
   end

   assign done = active_ff && ((err_ff != gncl_pkg::ST_LISTED) || (rest == '0));
   assign load = head_valid && (!active_ff || done);
   assign pop  = load;

   always_comb begin
      active_in    = active_ff;
      mask_in      = mask_ff;
      err_in       = err_ff;
      item_in      = item_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (active_ff) begin
         rsp_valid_in = 1'b1;
         if (err_ff != gncl_pkg::ST_LISTED) begin
            rsp_in.neighbour_index = '0;
            rsp_in.status          = err_ff;
            rsp_in.last            = 1'b1;
         end else begin
            rsp_in.neighbour_index = item_ff.cell_index + x_step + y_step;
            rsp_in.status          = gncl_pkg::ST_LISTED;
            rsp_in.last            = rest == '0;
            mask_in                = rest;
         end
         if (done) begin
            active_in = 1'b0;
         end
      end
      if (load) begin
         active_in = 1'b1;
         item_in   = head_entry;
         mask_in   = head_mask;
         if (head_entry.status != gncl_pkg::ST_LISTED) begin
            err_in = head_entry.status;
         end else if (head_mask == '0) begin
            err_in = gncl_pkg::ST_NO_CELL;
         end else begin
            err_in = gncl_pkg::ST_LISTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mask_ff <= mask_in;
      err_ff  <= err_in;
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ tb/sv/gncl_checker.sv @@
// Checker that predicts and compares the neighbour lists of the grid neighbour cell lister.
module gncl_checker
   import gncl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  rsp_type                rsp_payload,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     failures,
   output int                     pending,
   output int                     checked,
   output int                     flagged
);

   localparam int ENTER_STRAIGHT_FIRST = 7;
   localparam int ENTER_STRAIGHT_STOP  = 9;
   localparam int ENTER_DIAG_FIRST     = 6;
   localparam int ENTER_DIAG_STOP      = 10;
   localparam int LEAVE_STRAIGHT_FIRST = 3;
   localparam int LEAVE_STRAIGHT_STOP  = 5;
   localparam int LEAVE_DIAG_FIRST     = 2;
   localparam int LEAVE_DIAG_STOP      = 6;
   localparam int CENTRE_POS           = 8;

   // Column and row steps for the ring N, NE, E, SE, S, SW, W, NW and the centre.
   int ring_dx [9] = '{0, 1, 1, 1, 0, -1, -1, -1, 0};
   int ring_dy [9] = '{-1, -1, 0, 1, 1, 1, 0, -1, 0};

   grid_type grid;
   rsp_type  expected_cells [$];

   task automatic flag_mismatch(input string what);
      $display("mismatch: %s", what);
      failures++;
   endtask

   function automatic void list_neighbours(input req_type r);
      rsp_type run [$];
      rsp_type item;
      int      w;
      int      h;
      int      cx;
      int      cy;
      int      x;
      int      y;
      int      pos;
      int      first_step;
      int      last_step;
      bit      known_op;
      w = (grid.width > MAX_SIDE) ? MAX_SIDE : int'(grid.width);
      h = (grid.height > MAX_SIDE) ? MAX_SIDE : int'(grid.height);
      item = '0;
      if (int'(r.cell_index) >= int'(grid.count)) begin
         item.status = ST_OUT_OF_RANGE;
         item.last = 1'b1;
         expected_cells = {expected_cells, item};
         return;
      end
      known_op = 1'b1;
      first_step = 0;
      last_step = CENTRE_POS;
      case (r.operation)
         OP_BLOCK: begin
            first_step = 0;
            last_step = CENTRE_POS;
         end
         OP_ENTER: begin
            first_step = r.direction[0] ? ENTER_DIAG_FIRST : ENTER_STRAIGHT_FIRST;
            last_step = r.direction[0] ? ENTER_DIAG_STOP : ENTER_STRAIGHT_STOP;
         end
         OP_LEAVE: begin
            first_step = r.direction[0] ? LEAVE_DIAG_FIRST : LEAVE_STRAIGHT_FIRST;
            last_step = r.direction[0] ? LEAVE_DIAG_STOP : LEAVE_STRAIGHT_STOP;
         end
         default: known_op = 1'b0;
      endcase
      if (known_op && w != 0 && h != 0) begin
         cx = int'(r.cell_index) % w;
         cy = int'(r.cell_index) / w;
         for (int i = first_step; i <= last_step; i++) begin
            pos = (r.operation == OP_BLOCK) ? i : ((i + int'(r.direction)) % 8);
            x = cx + ring_dx[pos];
            y = cy + ring_dy[pos];
            if (x >= 0 && y >= 0 && x < w && y < h) begin
               item = '0;
               item.neighbour_index = CELL_W'(y * w + x);
               item.status = ST_LISTED;
               run = {run, item};
            end
         end
      end
      if (run.size() == 0) begin
         item = '0;
         item.status = ST_NO_CELL;
         run = {run, item};
      end
      run[run.size() - 1].last = 1'b1;
      expected_cells = {expected_cells, run};
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         grid.width = 1;
         grid.height = 1;
         grid.count = 1;
         expected_cells.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_cells.size() == 0) begin
               flag_mismatch($sformatf("unexpected result index %0d status %0d last %0b",
                  rsp_payload.neighbour_index, rsp_payload.status, rsp_payload.last));
            end else begin
               want = expected_cells.pop_front();
               checked++;
               if (rsp_payload.status != ST_LISTED) flagged++;
               if (rsp_payload.neighbour_index !== want.neighbour_index)
                  flag_mismatch($sformatf("neighbour_index got %0d want %0d",
                     rsp_payload.neighbour_index, want.neighbour_index));
               if (rsp_payload.status !== want.status)
                  flag_mismatch($sformatf("status got %0d want %0d",
                     rsp_payload.status, want.status));
               if (rsp_payload.last !== want.last)
                  flag_mismatch($sformatf("last got %0b want %0b",
                     rsp_payload.last, want.last));
            end
         end
         if (start && !busy) list_neighbours(req_payload);
         if (csr_write) begin
            case (csr_index)
               CSR_GRID_WIDTH:  grid.width = csr_wdata[SIDE_W-1:0];
               CSR_GRID_HEIGHT: grid.height = csr_wdata[SIDE_W-1:0];
               CSR_CELL_COUNT:  grid.count = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      pending <= expected_cells.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top that drives requests and grid settings into the grid neighbour cell lister.
module tb_top;
   import gncl_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT = 200000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_payload;
   logic                   rsp_valid;
   rsp_type                rsp_payload;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int failures;
   int pending;
   int checked;
   int flagged;
   int cycles;
   int requests;
   int shapes;
   int cfg_w;
   int cfg_h;
   int cfg_count;
   bit quiet_tail;

   grid_neighbour_cell_lister u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   gncl_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .pending     (pending),
      .checked     (checked),
      .flagged     (flagged)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input int centre, input int dir);
      int      gap;
      req_type next_req;
      gap = (!quiet_tail && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      next_req.operation = op;
      next_req.cell_index = CELL_W'(centre);
      next_req.direction = DIR_W'(dir);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         req_payload <= req_type'($urandom);
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_payload <= next_req;
      do @(posedge clock); while (busy);
      requests++;
   endtask

   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int w, input int h, input int c);
      cfg_w = w;
      cfg_h = h;
      cfg_count = c;
      shapes++;
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(negedge clock);
      csr_index <= CSR_GRID_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(negedge clock);
      csr_index <= CSR_CELL_COUNT;
      csr_wdata <= CSR_DATA_W'(c);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_random(input int n);
      int ew;
      int eh;
      int span;
      int centre;
      int row;
      int col;
      logic [OP_W-1:0] op;
      ew = (cfg_w > MAX_SIDE) ? MAX_SIDE : cfg_w;
      eh = (cfg_h > MAX_SIDE) ? MAX_SIDE : cfg_h;
      span = (cfg_count > 65536) ? 65536 : cfg_count;
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: centre = $urandom_range(0, 65535);
            1: centre = (span == 0) ? 0 : span - 1 + $urandom_range(0, 1);
            2, 3: begin
               if (ew == 0 || eh == 0) begin
                  centre = $urandom_range(0, 65535);
               end else begin
                  if ($urandom_range(0, 1) == 1) begin
                     col = ($urandom_range(0, 1) == 1) ? 0 : ew - 1;
                     row = $urandom_range(0, eh - 1);
                  end else begin
                     row = ($urandom_range(0, 1) == 1) ? 0 : eh - 1;
                     col = $urandom_range(0, ew - 1);
                  end
                  centre = row * ew + col;
               end
            end
            default: centre = (span == 0) ? $urandom_range(0, 65535) :
                                            $urandom_range(0, span - 1);
         endcase
         if (centre > 65535) centre = 65535;
         op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
         send_request(op, centre, $urandom_range(0, 7));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The reset shape is a single cell.
      cfg_w = 1;
      cfg_h = 1;
      cfg_count = 1;
      shapes = 1;
      send_request(OP_BLOCK, 0, 0);
      send_request(OP_ENTER, 0, 1);
      send_request(OP_LEAVE, 0, 2);
      send_request(OP_UNUSED, 0, 0);
      send_request(OP_BLOCK, 1, 0);
      send_request(OP_ENTER, 65535, 7);
      drain();

      // Corners, edges and the interior of a small grid, with every move kind.
      configure(5, 4, 20);
      send_request(OP_BLOCK, 0, 0);
      send_request(OP_BLOCK, 19, 0);
      send_request(OP_BLOCK, 7, 0);
      send_request(OP_BLOCK, 2, 0);
      send_request(OP_ENTER, 7, 0);
      send_request(OP_ENTER, 7, 1);
      send_request(OP_LEAVE, 7, 2);
      send_request(OP_LEAVE, 7, 3);
      send_request(OP_ENTER, 0, 5);
      send_request(OP_LEAVE, 19, 4);
      send_request(OP_LEAVE, 19, 7);
      send_request(OP_ENTER, 15, 6);
      send_request(OP_BLOCK, 20, 0);
      send_request(OP_UNUSED, 7, 0);
      send_request(OP_BLOCK, 65535, 0);
      drain();

      configure(256, 256, 65536);
      run_random(60);
      drain();
      configure(7, 5, 35);
      run_random(30);
      drain();
      configure(1, 9, 9);
      run_random(20);
      drain();
      configure(9, 1, 9);
      run_random(20);
      drain();
      configure(0, 4, 12);
      run_random(15);
      drain();
      configure(4, 0, 12);
      run_random(15);
      drain();
      configure(300, 511, 131071);
      run_random(30);
      drain();
      configure(3, 4, 50);
      run_random(25);
      drain();
      configure(256, 2, 0);
      run_random(10);
      drain();
      configure(37, 23, 851);
      run_random(30);
      drain();
      quiet_tail = 1'b1;
      configure(6, 6, 36);
      run_random(40);
      drain();

      $display("Sent %0d requests over %0d grid shapes, including zero and oversized sides.",
         requests, shapes);
      $display("Compared %0d results, %0d of them carrying an error status.", checked, flagged);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ grid_neighbour_cell_lister.f @@
hw/rtl/gncl_pkg.sv
hw/rtl/gncl_front.sv
hw/rtl/gncl_queue.sv
hw/rtl/gncl_back.sv
hw/rtl/grid_neighbour_cell_lister.sv
tb/sv/gncl_checker.sv
tb/sv/tb_top.sv
